// File: rtl/gcrt_pkg.sv
// Package for the group channel replay table: constants, codes, beat and state types.
`default_nettype none

package gcrt_pkg;

  // Table geometry
  localparam int GROUP_SLOTS  = 8;
  localparam int HEADER_BYTES = 16;
  localparam int TAG_BYTES    = 16;
  localparam int MIN_FRAME    = HEADER_BYTES + TAG_BYTES;
  localparam int SLOT_W       = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int VCNT_W       = $clog2(GROUP_SLOTS + 1);
  localparam int STAT_COUNT   = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_TYPE = 2'd1;

  // Command codes
  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_JOIN    = 3'd1;
  localparam logic [2:0] CMD_LEAVE   = 3'd2;
  localparam logic [2:0] CMD_SEND    = 3'd3;
  localparam logic [2:0] CMD_RECEIVE = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  // Status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NOT_MEMBER = 4'd1;
  localparam logic [3:0] ST_FULL       = 4'd2;
  localparam logic [3:0] ST_DUPLICATE  = 4'd3;
  localparam logic [3:0] ST_ALREADY    = 4'd4;
  localparam logic [3:0] ST_OWN        = 4'd5;
  localparam logic [3:0] ST_REPLAY     = 4'd6;
  localparam logic [3:0] ST_AUTH_FAIL  = 4'd7;
  localparam logic [3:0] ST_IGNORED    = 4'd8;

  // Statistics counter indexes; the valid-group count follows them
  localparam int CNT_SENT      = 0;
  localparam int CNT_RECEIVED  = 1;
  localparam int CNT_DECRYPTED = 2;
  localparam int CNT_AUTH_FAIL = 3;
  localparam int CNT_REPLAY    = 4;
  localparam logic [2:0] SEL_VALID_GROUPS = 3'(STAT_COUNT);

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] group_id;
    logic [31:0] sender;
    logic [31:0] sequence_req;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic        auth_ok;
    logic [2:0]  counter_select;
  } gcrt_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot;
    logic [31:0] result_id;
    logic [31:0] tx_sequence;
    logic [31:0] counter_value;
  } gcrt_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_EXEC
  } gcrt_state_t;

endpackage

`default_nettype wire

// File: rtl/group_channel_replay_table.sv
// Group channel table with anti-replay receive filter and statistics counters.
//
// One command per start beat. After acceptance the block scans the table one
// slot per cycle through a single shared 32-bit subtract/compare unit (SCAN),
// then compares the frame sequence with the stored receive sequence in the
// same unit (CHECK) and executes the update (EXEC). Busy stays high from
// acceptance through EXEC. The result strobe (out_valid) is registered from
// EXEC and rises in the same cycle busy drops, which is also the earliest
// cycle in which the next command can be taken: the block accepts no new
// command until the result of the last one is out. The result is shown for
// exactly one cycle and cannot be held off: the receiver must take it when
// out_valid is high. Configuration writes take effect at once and belong
// only between commands.
`default_nettype none

module group_channel_replay_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // command channel
  input  wire logic                               start,
  output      logic                               busy,
  input  wire gcrt_pkg::gcrt_in_t                 in_item,
  // result channel
  output      logic                               out_valid,
  output      gcrt_pkg::gcrt_out_t                out_item,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [gcrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_wdata
);

  localparam int SW = gcrt_pkg::SLOT_W;

  // Sequencer and request
  gcrt_pkg::gcrt_state_t state_r, state_nxt;
  gcrt_pkg::gcrt_in_t    req_r;
  logic [SW-1:0]         idx_r;
  logic                  hit_found_r, free_found_r;
  logic [SW-1:0]         hit_idx_r, free_idx_r;
  logic [gcrt_pkg::VCNT_W-1:0] vcount_r;
  logic                  not_newer_r, rx_nonzero_r;

  // Table and counters
  logic [gcrt_pkg::GROUP_SLOTS-1:0] valid_r;
  logic [31:0] entry_id_r   [gcrt_pkg::GROUP_SLOTS];
  logic [31:0] entry_tx_r   [gcrt_pkg::GROUP_SLOTS];
  logic [31:0] entry_rx_r   [gcrt_pkg::GROUP_SLOTS];
  logic [31:0] stat_r       [gcrt_pkg::STAT_COUNT];

  // Configuration
  logic [31:0] node_addr_r;
  logic [7:0]  msg_type_r;

  // Result register
  logic                 out_valid_r;
  gcrt_pkg::gcrt_out_t  out_r, res_nxt;

  // Execute controls
  logic new_entry, clr_entry, tx_wr, rx_wr;
  logic inc_sent, inc_recv, inc_dec, inc_auth, inc_replay;

  logic accept;
  logic scan_last;
  assign accept    = start && (state_r == gcrt_pkg::S_IDLE);
  assign busy      = (state_r != gcrt_pkg::S_IDLE);
  assign scan_last = (idx_r == SW'(gcrt_pkg::GROUP_SLOTS - 1));
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Shared subtract/compare unit: id match during scan, sequence check after
  logic [31:0] alu_a, alu_b;
  logic [32:0] alu_diff;
  logic        alu_eq, alu_le;
  always_comb begin
    if (state_r == gcrt_pkg::S_CHECK) begin
      alu_a = req_r.sequence_req;
      alu_b = entry_rx_r[hit_idx_r];
    end else begin
      alu_a = req_r.group_id;
      alu_b = entry_id_r[idx_r];
    end
  end
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_eq   = (alu_diff[31:0] == 32'd0);
  assign alu_le   = alu_diff[32] || alu_eq;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcrt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcrt_pkg::S_IDLE:  if (start) state_nxt = gcrt_pkg::S_SCAN;
      gcrt_pkg::S_SCAN:  if (scan_last) state_nxt = gcrt_pkg::S_CHECK;
      gcrt_pkg::S_CHECK: state_nxt = gcrt_pkg::S_EXEC;
      gcrt_pkg::S_EXEC:  state_nxt = gcrt_pkg::S_IDLE;
      default:           state_nxt = gcrt_pkg::S_IDLE;
    endcase
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    if (!rst_n) begin
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
      vcount_r     <= '0;
      not_newer_r  <= 1'b0;
      rx_nonzero_r <= 1'b0;
    end else if (accept) begin
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
      vcount_r     <= '0;
    end else if (state_r == gcrt_pkg::S_SCAN) begin
      idx_r <= idx_r + SW'(1);
      if (valid_r[idx_r]) begin
        vcount_r <= vcount_r + gcrt_pkg::VCNT_W'(1);
        if (alu_eq && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= idx_r;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
    end else if (state_r == gcrt_pkg::S_CHECK) begin
      not_newer_r  <= alu_le;
      rx_nonzero_r <= (entry_rx_r[hit_idx_r] != 32'd0);
    end
  end

  // Execute: decide result and table/counter updates
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = gcrt_pkg::ST_IGNORED;
    new_entry  = 1'b0;
    clr_entry  = 1'b0;
    tx_wr      = 1'b0;
    rx_wr      = 1'b0;
    inc_sent   = 1'b0;
    inc_recv   = 1'b0;
    inc_dec    = 1'b0;
    inc_auth   = 1'b0;
    inc_replay = 1'b0;
    case (req_r.command)
      gcrt_pkg::CMD_CREATE, gcrt_pkg::CMD_JOIN: begin
        if (hit_found_r) begin
          res_nxt.slot = 3'(hit_idx_r);
          if (req_r.command == gcrt_pkg::CMD_CREATE) begin
            res_nxt.status = gcrt_pkg::ST_DUPLICATE;
          end else begin
            res_nxt.status    = gcrt_pkg::ST_ALREADY;
            res_nxt.result_id = req_r.group_id;
          end
        end else if (!free_found_r) begin
          res_nxt.status = gcrt_pkg::ST_FULL;
        end else begin
          new_entry         = 1'b1;
          res_nxt.status    = gcrt_pkg::ST_OK;
          res_nxt.slot      = 3'(free_idx_r);
          res_nxt.result_id = req_r.group_id;
        end
      end
      gcrt_pkg::CMD_LEAVE: begin
        if (!hit_found_r) begin
          res_nxt.status = gcrt_pkg::ST_NOT_MEMBER;
        end else begin
          clr_entry      = 1'b1;
          res_nxt.status = gcrt_pkg::ST_OK;
          res_nxt.slot   = 3'(hit_idx_r);
        end
      end
      gcrt_pkg::CMD_SEND: begin
        if (!hit_found_r) begin
          res_nxt.status = gcrt_pkg::ST_NOT_MEMBER;
        end else begin
          tx_wr               = 1'b1;
          inc_sent            = 1'b1;
          res_nxt.status      = gcrt_pkg::ST_OK;
          res_nxt.slot        = 3'(hit_idx_r);
          res_nxt.tx_sequence = entry_tx_r[hit_idx_r];
        end
      end
      gcrt_pkg::CMD_RECEIVE: begin
        // filter order: type/length, membership, own, replay, auth
        if (req_r.frame_type != msg_type_r ||
            req_r.frame_length < 16'(gcrt_pkg::MIN_FRAME)) begin
          res_nxt.status = gcrt_pkg::ST_IGNORED;
        end else if (!hit_found_r) begin
          res_nxt.status = gcrt_pkg::ST_NOT_MEMBER;
        end else begin
          res_nxt.slot = 3'(hit_idx_r);
          if (req_r.sender == node_addr_r) begin
            res_nxt.status = gcrt_pkg::ST_OWN;
          end else begin
            inc_recv = 1'b1;
            if (rx_nonzero_r && not_newer_r) begin
              inc_replay     = 1'b1;
              res_nxt.status = gcrt_pkg::ST_REPLAY;
            end else if (!req_r.auth_ok) begin
              inc_auth       = 1'b1;
              res_nxt.status = gcrt_pkg::ST_AUTH_FAIL;
            end else begin
              rx_wr          = 1'b1;
              inc_dec        = 1'b1;
              res_nxt.status = gcrt_pkg::ST_OK;
            end
          end
        end
      end
      gcrt_pkg::CMD_READ: begin
        res_nxt.status = gcrt_pkg::ST_OK;
        if (req_r.counter_select < 3'(gcrt_pkg::STAT_COUNT)) begin
          res_nxt.counter_value = stat_r[req_r.counter_select];
        end else if (req_r.counter_select == gcrt_pkg::SEL_VALID_GROUPS) begin
          res_nxt.counter_value = 32'(vcount_r);
        end
      end
      default: res_nxt.status = gcrt_pkg::ST_IGNORED;
    endcase
  end

  // Valid bits and counters (reset), entry payload (no reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < gcrt_pkg::STAT_COUNT; i++) begin
        stat_r[i] <= 32'd0;
      end
    end else if (state_r == gcrt_pkg::S_EXEC) begin
      if (new_entry) valid_r[free_idx_r] <= 1'b1;
      if (clr_entry) valid_r[hit_idx_r]  <= 1'b0;
      if (inc_sent)   stat_r[gcrt_pkg::CNT_SENT]      <= stat_r[gcrt_pkg::CNT_SENT] + 32'd1;
      if (inc_recv)   stat_r[gcrt_pkg::CNT_RECEIVED]  <= stat_r[gcrt_pkg::CNT_RECEIVED] + 32'd1;
      if (inc_dec)    stat_r[gcrt_pkg::CNT_DECRYPTED] <= stat_r[gcrt_pkg::CNT_DECRYPTED] + 32'd1;
      if (inc_auth)   stat_r[gcrt_pkg::CNT_AUTH_FAIL] <= stat_r[gcrt_pkg::CNT_AUTH_FAIL] + 32'd1;
      if (inc_replay) stat_r[gcrt_pkg::CNT_REPLAY]    <= stat_r[gcrt_pkg::CNT_REPLAY] + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gcrt_pkg::S_EXEC) begin
      if (new_entry) begin
        entry_id_r[free_idx_r] <= req_r.group_id;
        entry_tx_r[free_idx_r] <= 32'd1;
        entry_rx_r[free_idx_r] <= 32'd0;
      end
      if (tx_wr) entry_tx_r[hit_idx_r] <= entry_tx_r[hit_idx_r] + 32'd1;
      if (rx_wr) entry_rx_r[hit_idx_r] <= req_r.sequence_req;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 32'd0;
      msg_type_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcrt_pkg::CFG_NODE_ADDRESS: node_addr_r <= cfg_wdata;
        gcrt_pkg::CFG_MESSAGE_TYPE: msg_type_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == gcrt_pkg::S_EXEC);
    end
    if (state_r == gcrt_pkg::S_EXEC) begin
      out_r <= res_nxt;
    end
  end

  // Assertions
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == gcrt_pkg::S_EXEC))
    else $error("result beat without execute cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == gcrt_pkg::ST_FULL) |->
      (out_r.slot == 3'd0 && out_r.result_id == 32'd0))
    else $error("full table result carries slot or id");

  a_hit_free_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcrt_pkg::S_EXEC && hit_found_r && free_found_r) |->
      (hit_idx_r != free_idx_r))
    else $error("hit slot and free slot coincide");

  a_vcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcrt_pkg::S_EXEC) |->
      (vcount_r <= gcrt_pkg::VCNT_W'(gcrt_pkg::GROUP_SLOTS)))
    else $error("valid group count beyond table size");

endmodule

`default_nettype wire

// File: bench/gcrt_result_checker.sv
// Result checker for the group channel table: mirrors the table, predicts and checks results.
`default_nettype none

module gcrt_result_checker
  import gcrt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire gcrt_in_t             in_item,
  input  wire logic                 out_valid,
  input  wire gcrt_out_t            out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  output int                        err_cnt,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the group table and statistics
  logic        grp_valid  [GROUP_SLOTS];
  logic [31:0] grp_id     [GROUP_SLOTS];
  logic        grp_admin  [GROUP_SLOTS];
  logic [31:0] grp_tx_seq [GROUP_SLOTS];
  logic [31:0] grp_rx_seq [GROUP_SLOTS];
  logic [31:0] stat_cnt   [STAT_COUNT];
  logic [31:0] own_addr;
  logic [7:0]  msg_type;

  // Results still owed by the block, oldest first
  gcrt_out_t   outcome_q [$];
  int          err_total = 0;

  function automatic int find_group(input logic [31:0] gid);
    for (int i = 0; i < GROUP_SLOTS; i++)
      if (grp_valid[i] && grp_id[i] == gid) return i;
    return -1;
  endfunction

  // Apply one command to the mirror and return the result it should produce
  function automatic gcrt_out_t apply_command(input gcrt_in_t c);
    gcrt_out_t r;
    int        hit;
    int        fr;
    r = '0;
    r.status = ST_IGNORED;
    hit = find_group(c.group_id);
    fr = -1;
    case (c.command)
      CMD_CREATE, CMD_JOIN: begin
        if (hit >= 0) begin
          r.slot = SLOT_W'(hit);
          if (c.command == CMD_CREATE) begin
            r.status = ST_DUPLICATE;
          end else begin
            r.status = ST_ALREADY;
            r.result_id = c.group_id;
          end
        end else begin
          // lowest free slot wins
          for (int i = GROUP_SLOTS - 1; i >= 0; i--)
            if (!grp_valid[i]) fr = i;
          if (fr < 0) begin
            r.status = ST_FULL;
          end else begin
            grp_valid[fr]  = 1'b1;
            grp_id[fr]     = c.group_id;
            grp_admin[fr]  = (c.command == CMD_CREATE);
            grp_tx_seq[fr] = 32'd1;
            grp_rx_seq[fr] = 32'd0;
            r.status    = ST_OK;
            r.slot      = SLOT_W'(fr);
            r.result_id = c.group_id;
          end
        end
      end
      CMD_LEAVE: begin
        if (hit < 0) begin
          r.status = ST_NOT_MEMBER;
        end else begin
          grp_valid[hit] = 1'b0;
          r.status = ST_OK;
          r.slot   = SLOT_W'(hit);
        end
      end
      CMD_SEND: begin
        if (hit < 0) begin
          r.status = ST_NOT_MEMBER;
        end else begin
          r.tx_sequence   = grp_tx_seq[hit];
          grp_tx_seq[hit] = grp_tx_seq[hit] + 32'd1;
          stat_cnt[CNT_SENT] = stat_cnt[CNT_SENT] + 32'd1;
          r.status = ST_OK;
          r.slot   = SLOT_W'(hit);
        end
      end
      CMD_RECEIVE: begin
        // filter order: type/length, membership, own sender, replay, auth
        if (c.frame_type != msg_type || c.frame_length < 16'(MIN_FRAME)) begin
          r.status = ST_IGNORED;
        end else if (hit < 0) begin
          r.status = ST_NOT_MEMBER;
        end else begin
          r.slot = SLOT_W'(hit);
          if (c.sender == own_addr) begin
            r.status = ST_OWN;
          end else begin
            stat_cnt[CNT_RECEIVED] = stat_cnt[CNT_RECEIVED] + 32'd1;
            if (grp_rx_seq[hit] != 32'd0 && c.sequence_req <= grp_rx_seq[hit]) begin
              stat_cnt[CNT_REPLAY] = stat_cnt[CNT_REPLAY] + 32'd1;
              r.status = ST_REPLAY;
            end else if (!c.auth_ok) begin
              stat_cnt[CNT_AUTH_FAIL] = stat_cnt[CNT_AUTH_FAIL] + 32'd1;
              r.status = ST_AUTH_FAIL;
            end else begin
              grp_rx_seq[hit] = c.sequence_req;
              stat_cnt[CNT_DECRYPTED] = stat_cnt[CNT_DECRYPTED] + 32'd1;
              r.status = ST_OK;
            end
          end
        end
      end
      CMD_READ: begin
        r.status = ST_OK;
        if (c.counter_select < 3'(STAT_COUNT)) begin
          r.counter_value = stat_cnt[c.counter_select];
        end else if (c.counter_select == SEL_VALID_GROUPS) begin
          for (int i = 0; i < GROUP_SLOTS; i++)
            r.counter_value = r.counter_value + 32'(grp_valid[i]);
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  // Watch config writes, result beats and accepted commands at each edge
  always @(posedge clk) begin : watch
    gcrt_out_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < GROUP_SLOTS; i++) grp_valid[i] = 1'b0;
      for (int i = 0; i < STAT_COUNT; i++) stat_cnt[i] = 32'd0;
      own_addr = 32'd0;
      msg_type = 8'd0;
      outcome_q.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        if (cfg_index == CFG_NODE_ADDRESS) own_addr = cfg_wdata;
        else if (cfg_index == CFG_MESSAGE_TYPE) msg_type = cfg_wdata[7:0];
      end
      // result beat: compare before queuing a command accepted on this edge
      if (out_valid === 1'b1) begin
        if (outcome_q.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("unexpected result beat: status %0d slot %0d id %h tx %h cnt %h",
                     out_item.status, out_item.slot, out_item.result_id,
                     out_item.tx_sequence, out_item.counter_value);
        end else begin
          exp_r = outcome_q.pop_front();
          if (out_item.status !== exp_r.status || out_item.slot !== exp_r.slot ||
              out_item.result_id !== exp_r.result_id ||
              out_item.tx_sequence !== exp_r.tx_sequence ||
              out_item.counter_value !== exp_r.counter_value) begin
            err_total++;
            if (err_total <= 10) begin
              $display("mismatch: expected status %0d slot %0d id %h tx %h cnt %h",
                       exp_r.status, exp_r.slot, exp_r.result_id,
                       exp_r.tx_sequence, exp_r.counter_value);
              $display("          got      status %0d slot %0d id %h tx %h cnt %h",
                       out_item.status, out_item.slot, out_item.result_id,
                       out_item.tx_sequence, out_item.counter_value);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) outcome_q.push_back(apply_command(in_item));
    end
    err_cnt <= err_total;
    pending <= outcome_q.size();
  end

endmodule

`default_nettype wire

// File: bench/group_channel_replay_table_test.sv
// Top of the group channel table testbench: clock, reset, command stimulus and verdict.
`default_nettype none

module group_channel_replay_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gcrt_pkg::*;

  localparam int LATENCY     = GROUP_SLOTS + 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 490;
  localparam int POOL_N      = 12;
  localparam logic [2:0] CMD_RESERVED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  gcrt_in_t             in_item = '0;
  logic                 out_valid;
  gcrt_out_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;
  int                   err_cnt;
  int                   pending;
  int                   cycle_cnt = 0;

  // Stimulus-side view: group id pool, last issued sequence per id, config copy
  logic [31:0] id_pool  [POOL_N];
  logic [31:0] seq_hint [POOL_N];
  logic [31:0] node_addr = 32'd0;
  logic [7:0]  type_code = 8'd0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  group_channel_replay_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gcrt_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .err_cnt   (err_cnt),
    .pending   (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** group_channel_replay_table: FAILED **");
      $finish;
    end
  end

  function automatic gcrt_in_t beat_of(input logic [2:0] cmd, input logic [31:0] gid,
                                       input logic [31:0] snd, input logic [31:0] seq,
                                       input logic [7:0] ftype, input logic [15:0] flen,
                                       input logic auth, input logic [2:0] sel);
    gcrt_in_t b;
    b.command        = cmd;
    b.group_id       = gid;
    b.sender         = snd;
    b.sequence_req   = seq;
    b.frame_type     = ftype;
    b.frame_length   = flen;
    b.auth_ok        = auth;
    b.counter_select = sel;
    return b;
  endfunction

  // Mostly well-formed traffic on a small id pool, with some noise
  function automatic gcrt_in_t random_command();
    gcrt_in_t b;
    int       k;
    int       pick;
    k = $urandom_range(0, POOL_N - 1);
    pick = $urandom_range(0, 99);
    b = beat_of(CMD_RESERVED, id_pool[k], $urandom, $urandom, 8'($urandom),
                16'($urandom), 1'($urandom), 3'($urandom));
    if (pick < 14) begin
      b.command = CMD_CREATE;
    end else if (pick < 24) begin
      b.command = CMD_JOIN;
    end else if (pick < 34) begin
      b.command = CMD_LEAVE;
    end else if (pick < 48) begin
      b.command = CMD_SEND;
    end else if (pick < 85) begin
      b.command = CMD_RECEIVE;
      if ($urandom_range(0, 9) != 0) b.frame_type = type_code;
      pick = $urandom_range(0, 9);
      if (pick < 8) b.frame_length = 16'($urandom_range(MIN_FRAME, 65535));
      else if (pick == 8) b.frame_length = 16'(MIN_FRAME);
      else b.frame_length = 16'($urandom_range(0, MIN_FRAME - 1));
      if ($urandom_range(0, 9) == 0) b.sender = node_addr;
      b.auth_ok = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        seq_hint[k] = seq_hint[k] + 32'($urandom_range(1, 500));
        b.sequence_req = seq_hint[k];
      end else if (pick < 92) begin
        // old or repeated sequence
        b.sequence_req = seq_hint[k] - 32'($urandom_range(0, 2));
      end else begin
        seq_hint[k] = b.sequence_req;
      end
    end else if (pick < 93) begin
      b.command = CMD_READ;
    end else begin
      b.command = 3'($urandom_range(0, 7));
    end
    return b;
  endfunction

  // Present one command beat and hold it until the block takes it
  task automatic issue(input gcrt_in_t b);
    in_item <= b;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until every owed result beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both registers plus an unused index, back to back
  task automatic program_regs(input logic [31:0] node, input logic [7:0] mtype);
    node_addr = node;
    type_code = mtype;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NODE_ADDRESS;
    cfg_wdata <= node;
    @(posedge clk);
    cfg_index <= CFG_MESSAGE_TYPE;
    cfg_wdata <= ($urandom & 32'hFFFF_FF00) | 32'(mtype);
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_N; i++) begin
      id_pool[i]  = $urandom;
      seq_hint[i] = 32'd0;
    end
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
  endtask

  // Directed walk through table fill, lookups and every receive filter
  task automatic run_directed();
    logic [31:0] peer;
    logic [15:0] ok_len;
    peer   = ~node_addr;
    ok_len = 16'(MIN_FRAME);
    issue(beat_of(CMD_CREATE, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    // duplicate create
    issue(beat_of(CMD_CREATE, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    issue(beat_of(CMD_JOIN, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    // join of a present id
    issue(beat_of(CMD_JOIN, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    for (int i = 1; i <= 6; i++)
      issue(beat_of(CMD_CREATE, 32'(i), 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    // table full for create and join
    issue(beat_of(CMD_CREATE, 32'd7, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    issue(beat_of(CMD_JOIN, 32'd8, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    issue(beat_of(CMD_LEAVE, 32'd3, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    issue(beat_of(CMD_LEAVE, 32'd3, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    issue(beat_of(CMD_SEND, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    issue(beat_of(CMD_SEND, 32'd3, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
    // receive: wrong type, one byte short, absent id, own sender
    issue(beat_of(CMD_RECEIVE, 32'h0, peer, 32'd1, ~type_code, ok_len, 1'b1, 3'd0));
    issue(beat_of(CMD_RECEIVE, 32'h0, peer, 32'd1, type_code, ok_len - 16'd1, 1'b1, 3'd0));
    issue(beat_of(CMD_RECEIVE, 32'd3, peer, 32'd1, type_code, ok_len, 1'b1, 3'd0));
    issue(beat_of(CMD_RECEIVE, 32'h0, node_addr, 32'd1, type_code, ok_len, 1'b1, 3'd0));
    // accept, replay of the same sequence, then auth failure at max sequence
    issue(beat_of(CMD_RECEIVE, 32'h0, peer, 32'd5, type_code, 16'hFFFF, 1'b1, 3'd0));
    issue(beat_of(CMD_RECEIVE, 32'h0, peer, 32'd5, type_code, ok_len, 1'b1, 3'd0));
    issue(beat_of(CMD_RECEIVE, 32'h0, peer, 32'hFFFF_FFFF, type_code, ok_len, 1'b0, 3'd0));
    issue(beat_of(CMD_READ, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, SEL_VALID_GROUPS));
    issue(beat_of(CMD_RESERVED, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0, 1'b0, 3'd0));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    program_regs(32'h8000_0001, 8'h5C);
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0:       program_regs(32'h0000_0000, 8'h00);
        1:       program_regs(32'hFFFF_FFFF, 8'hFF);
        default: program_regs($urandom, 8'($urandom));
      endcase
      refill_pool();
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // one long stretch in the third phase runs back to back
        if (!(ph == 2 && i >= 100 && i < 400) && $urandom_range(0, 99) < 11)
          idle_gap($urandom_range(1, 2 * LATENCY));
        issue(random_command());
      end
    end
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** group_channel_replay_table: PASSED **");
    end else begin
      $display("** group_channel_replay_table: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
